[hdl/tile_histogram_peak_threshold_macros.svh]
// Assertion macros for the tile histogram peak threshold block.
`ifndef TILE_HISTOGRAM_PEAK_THRESHOLD_MACROS_SVH
`define TILE_HISTOGRAM_PEAK_THRESHOLD_MACROS_SVH

`ifndef SYNTHESIS
// Assert a property on every rising edge outside reset.
`define THPT_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("thpt assertion failed");
// Assert that a condition never holds outside reset.
`define THPT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("thpt forbidden condition seen");
`else
`define THPT_ASSERT(lbl, ck, rn, prop)
`define THPT_NEVER(lbl, ck, rn, cond)
`endif

`endif

[hdl/thpt_pkg.sv]
// Shared types, constants and helpers of the tile histogram peak threshold block.
`default_nettype none
package thpt_pkg;

	localparam int MAX_TILE_WIDTH_DEF  = 16;
	localparam int MAX_TILE_HEIGHT_DEF = 16;
	localparam int BINS                = 256;
	localparam int BIN_W               = 8;
	localparam int PIX_W               = 8;
	localparam int HIST_W              = 9;
	localparam int CNT_W               = 9;
	localparam int THR_W               = 9;
	localparam int MASK_W              = 16;
	localparam int MASK_IDX_W          = 4;
	localparam int ROW_IDX_W           = 4;
	localparam int CFG_DIM_W           = 5;
	localparam int CFG_DATA_W          = 5;
	localparam int CFG_IDX_W           = 2;
	localparam int DIM_RESET           = 16;
	localparam int DAY_OFFSET          = 20;
	localparam int NIGHT_OFFSET        = 15;

	typedef logic [PIX_W-1:0]     pixel_t;
	typedef logic [MASK_W-1:0]    mask_t;
	typedef logic [ROW_IDX_W-1:0] row_idx_t;
	typedef logic [BIN_W-1:0]     bin_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH  = 2'd0,
		REG_TILE_HEIGHT = 2'd1,
		REG_DAY_MODE    = 2'd2
	} cfg_reg_t;

	// Zero acts as one, anything above the maximum saturates.
	function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v, input int maxv);
		int r;
		r = int'(v);
		if (r == 0) begin
			r = 1;
		end else if (r > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/thpt_ifs.sv]
// Valid/ready channel interfaces for pixels in and row masks out.
`default_nettype none
interface thpt_pix_if;
	import thpt_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface thpt_row_if;
	import thpt_pkg::*;
	logic     valid;
	logic     ready;
	row_idx_t row_index;
	mask_t    row_mask;
	pixel_t   peak_level;
	logic     last_row;
	modport source (output valid, output row_index, output row_mask, output peak_level,
		output last_row, input ready);
	modport sink (input valid, input row_index, input row_mask, input peak_level,
		input last_row, output ready);
endinterface
`default_nettype wire

[hdl/tile_histogram_peak_threshold.sv]
// Per-tile histogram peak search and row threshold mask generation.
// Each pixel is a histogram read on transfer, then an increment; ready is low during the
// increment. After the tile's last pixel the peak scan reads every bin of the histogram
// RAM, then each row is read from the tile store RAM, holding while the output stalls.
// Reset sets the registers to width 16, height 16, night mode and empties the histogram
// by clearing its per-bin valid flags at once; no clearing pass is needed.
`default_nettype none
`include "tile_histogram_peak_threshold_macros.svh"
module tile_histogram_peak_threshold #(
	parameter int MAX_TILE_WIDTH  = thpt_pkg::MAX_TILE_WIDTH_DEF,
	parameter int MAX_TILE_HEIGHT = thpt_pkg::MAX_TILE_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	thpt_pix_if.sink                        pix,
	thpt_row_if.source                      rows,
	input  logic                            cfg_we,
	input  logic [thpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thpt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import thpt_pkg::*;

	localparam int STORE_DEPTH = MAX_TILE_WIDTH * MAX_TILE_HEIGHT;
	localparam int SA_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int W_W    = $clog2(MAX_TILE_WIDTH + 1);
	localparam int H_W    = $clog2(MAX_TILE_HEIGHT + 1);
	localparam int SIZE_W = $clog2(STORE_DEPTH + 1);
	localparam int COL_W  = (MAX_TILE_WIDTH > 1) ? $clog2(MAX_TILE_WIDTH) : 1;
	localparam int ROW_W  = (MAX_TILE_HEIGHT > 1) ? $clog2(MAX_TILE_HEIGHT) : 1;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_HIST     = 7'b0000010,
		S_SCAN     = 7'b0000100,
		S_SCAN_END = 7'b0001000,
		S_ROW      = 7'b0010000,
		S_ROW_END  = 7'b0100000,
		S_EMIT     = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [CFG_DIM_W-1:0]   tile_width_q;
	logic [CFG_DIM_W-1:0]   tile_height_q;
	logic                   day_mode_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [BINS-1:0]        hist_vld_q;
	bin_t                   bin_q;
	logic [SA_W-1:0]        store_addr_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic                   scan_s1;
	logic                   row_s1;
	logic                   out_vld_q;

	pixel_t                 pix_q;
	bin_t                   scan_bin_s1;
	logic [COL_W-1:0]       col_s1;
	logic [HIST_W-1:0]      best_q;
	bin_t                   peak_q;
	mask_t                  mask_q;
	row_idx_t               out_row_q;
	mask_t                  out_mask_q;
	pixel_t                 out_peak_q;
	logic                   out_last_q;

	logic [W_W-1:0]         w_dim;
	logic [H_W-1:0]         h_dim;
	logic [SIZE_W-1:0]      size_v;
	logic                   pix_xfer;
	logic                   out_free;
	logic                   tile_done;
	logic                   row_last_col;
	logic                   last_row_v;
	logic [31:0]            cnt_ext;
	logic [31:0]            col_ext;
	logic [31:0]            row_ext;

	logic                   hist_we;
	bin_t                   hist_raddr;
	logic [HIST_W-1:0]      hist_wdata;
	logic [HIST_W-1:0]      hist_rdata;
	logic [HIST_W-1:0]      hist_cur;
	logic [HIST_W-1:0]      scan_cnt;
	logic                   store_we;
	logic [SA_W-1:0]        store_waddr;
	pixel_t                 store_rdata;

	logic [THR_W-1:0]       thresh;
	logic [HIST_W-1:0]      cmp_a;
	logic [HIST_W-1:0]      cmp_b;
	logic                   cmp_gt;
	logic                   bit_hit;

	assign w_dim  = W_W'(clamp_dim(tile_width_q, MAX_TILE_WIDTH));
	assign h_dim  = H_W'(clamp_dim(tile_height_q, MAX_TILE_HEIGHT));
	assign size_v = SIZE_W'(32'(w_dim) * 32'(h_dim));

	assign pix.ready = (state_q == S_IDLE);
	assign pix_xfer  = pix.valid && pix.ready;
	assign out_free  = !out_vld_q || rows.ready;

	assign cnt_ext      = 32'(cnt_q);
	assign col_ext      = 32'(col_q);
	assign row_ext      = 32'(row_q);
	assign tile_done    = cnt_ext >= 32'(size_v);
	assign row_last_col = col_ext == (32'(w_dim) - 32'd1);
	assign last_row_v   = (row_ext + 32'd1) == 32'(h_dim);

	// Histogram: read the bin on transfer, write the incremented count next cycle.
	assign hist_raddr = (state_q == S_IDLE) ? pix.pixel : bin_q;
	assign hist_cur   = hist_vld_q[pix_q] ? hist_rdata : '0;
	assign hist_wdata = hist_cur + HIST_W'(1);
	assign hist_we    = (state_q == S_HIST);
	assign scan_cnt   = hist_vld_q[scan_bin_s1] ? hist_rdata : '0;

	assign store_we    = pix_xfer && (cnt_ext < 32'(STORE_DEPTH));
	assign store_waddr = cnt_ext[SA_W-1:0];

	// One comparator serves both the peak scan and the row threshold test.
	assign thresh  = THR_W'(peak_q) + (day_mode_q ? THR_W'(DAY_OFFSET) : THR_W'(NIGHT_OFFSET));
	assign cmp_a   = scan_s1 ? scan_cnt : HIST_W'(store_rdata);
	assign cmp_b   = scan_s1 ? best_q : HIST_W'(thresh);
	assign cmp_gt  = cmp_a > cmp_b;
	assign bit_hit = row_s1 && cmp_gt && (32'(col_s1) < 32'(MASK_W));

	thpt_ram #(
		.WIDTH (HIST_W),
		.DEPTH (BINS)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (pix_q),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	thpt_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (pix.pixel),
		.raddr (store_addr_q),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= CFG_DIM_W'(DIM_RESET);
			tile_height_q <= CFG_DIM_W'(DIM_RESET);
			day_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
				REG_TILE_HEIGHT: tile_height_q <= cfg_data;
				REG_DAY_MODE:    day_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			hist_vld_q   <= '0;
			bin_q        <= '0;
			store_addr_q <= '0;
			col_q        <= '0;
			row_q        <= '0;
			scan_s1      <= 1'b0;
			row_s1       <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			scan_s1 <= 1'b0;
			row_s1  <= 1'b0;
			if (state_q == S_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rows.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pix_xfer) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_HIST;
					end
				end
				S_HIST: begin
					hist_vld_q[pix_q] <= 1'b1;
					bin_q             <= '0;
					state_q           <= tile_done ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					scan_s1 <= 1'b1;
					bin_q   <= bin_q + BIN_W'(1);
					if (bin_q == BIN_W'(BINS - 1)) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					// Empty the histogram and the count for the next tile.
					hist_vld_q   <= '0;
					cnt_q        <= '0;
					store_addr_q <= '0;
					col_q        <= '0;
					row_q        <= '0;
					state_q      <= S_ROW;
				end
				S_ROW: begin
					row_s1       <= 1'b1;
					store_addr_q <= store_addr_q + SA_W'(1);
					col_q        <= col_q + COL_W'(1);
					if (row_last_col) begin
						state_q <= S_ROW_END;
					end
				end
				S_ROW_END: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						col_q <= '0;
						if (last_row_v) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + ROW_W'(1);
							state_q <= S_ROW;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			pix_q <= pix.pixel;
		end
		scan_bin_s1 <= bin_q;
		col_s1      <= col_q;
		if (state_q == S_HIST) begin
			best_q <= '0;
			peak_q <= '0;
		end else if (scan_s1 && cmp_gt) begin
			// Strict compare keeps the lowest bin on a tie.
			best_q <= scan_cnt;
			peak_q <= scan_bin_s1;
		end
		if (state_q == S_SCAN_END || (state_q == S_EMIT && out_free)) begin
			mask_q <= '0;
		end else if (bit_hit) begin
			mask_q[MASK_IDX_W'(col_s1)] <= 1'b1;
		end
		if (state_q == S_EMIT && out_free) begin
			out_row_q  <= row_ext[ROW_IDX_W-1:0];
			out_mask_q <= mask_q;
			out_peak_q <= peak_q;
			out_last_q <= last_row_v;
		end
	end

	assign rows.valid      = out_vld_q;
	assign rows.row_index  = out_row_q;
	assign rows.row_mask   = out_mask_q;
	assign rows.peak_level = out_peak_q;
	assign rows.last_row   = out_last_q;

	`THPT_ASSERT(a_hist_emptied, clk, arst_n, (state_q == S_SCAN_END) |=> (hist_vld_q == '0))
	`THPT_NEVER(a_one_compare_user, clk, arst_n, scan_s1 && row_s1)
	`THPT_ASSERT(a_rows_after_clear, clk, arst_n, (state_q == S_ROW) |-> (cnt_q == '0))
	`THPT_ASSERT(a_emit_loads_out, clk, arst_n, (state_q == S_EMIT && out_free) |=> rows.valid)

endmodule
`default_nettype wire

[hdl/thpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module thpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
